FILE: rtl/tks_pkg.sv
// Shared constants for the top-k largest value selector.
package tks_pkg;

   localparam int DEF_MAX_KEEP    = 16;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int KEEP_W = 5;
   localparam int RANK_W = 4;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

endpackage

FILE: rtl/tks_if.sv
// Request and response channel interfaces of the top-k largest value selector.
interface tks_req_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] sample_value;
   logic                          last_in_set;

   modport source (output valid, output sample_value, output last_in_set, input ready);
   modport sink   (input valid, input sample_value, input last_in_set, output ready);
endinterface

interface tks_rsp_if #(
   parameter int VALUE_WIDTH = 32
) ();
   import tks_pkg::*;

   logic                          valid;
   logic                          ready;
   logic signed [VALUE_WIDTH-1:0] kept_value;
   logic [RANK_W-1:0]             rank;
   logic                          final_result;

   modport source (output valid, output kept_value, output rank, output final_result,
                   input ready);
   modport sink   (input valid, input kept_value, input rank, input final_result,
                   output ready);
endinterface

FILE: rtl/top_k_largest_selector.sv
// Top level of the top-k largest value selector: sequencer, compare unit and output word.
//
// The block takes a stream of signed words on req and keeps the keep_count
// largest of the current set in a min-heap held in a small RAM. One signed
// comparator is shared by every step; a sequencer walks the heap one level at
// a time. While the heap fills, an accepted word goes into the next free slot
// and climbs while it is smaller than its parent; once the heap holds keep_count
// words, the word is compared with the root and dropped unless the root is smaller,
// else it replaces the root and sifts down toward the leaves. Each sift step waits
// on the registered RAM read and shares the single comparator. req.ready is
// high only while the sequencer is idle, so no new word is taken mid-update.
// A word with last_in_set starts the report: the root is popped, the heap is
// repaired, and the next root follows, so the kept values come out on rsp in
// ascending order with rank counting from 0 and final_result on the last one.
// Between report words the last entry, moved to the root, sifts down.
// The store is empty afterwards.
// The output word sits in a register: while rsp.ready is low it holds, and the
// heap repair behind it continues until the next word is ready. keep_count is
// written through csr_write_enable and csr_write_data.
// Reset empties the heap, drops any pending word and sets keep_count to 16.
module top_k_largest_selector #(
   parameter int MAX_KEEP    = tks_pkg::DEF_MAX_KEEP,
   parameter int VALUE_WIDTH = tks_pkg::DEF_VALUE_WIDTH
) (
   input  logic                        clock,
   input  logic                        reset,
   tks_req_if.sink                     req,
   tks_rsp_if.source                   rsp,
   input  logic                        csr_write_enable,
   input  logic [tks_pkg::KEEP_W-1:0]  csr_write_data
);
   import tks_pkg::*;

   localparam int AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int FW = $clog2(MAX_KEEP + 1);
   localparam int CW = AW + 2;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_UP_RD    = 4'd1;
   localparam logic [3:0] ST_UP_CMP   = 4'd2;
   localparam logic [3:0] ST_ROOT_CMP = 4'd3;
   localparam logic [3:0] ST_DN_RD    = 4'd4;
   localparam logic [3:0] ST_DN_L     = 4'd5;
   localparam logic [3:0] ST_DN_R     = 4'd6;
   localparam logic [3:0] ST_DONE     = 4'd7;
   localparam logic [3:0] ST_POP_RD   = 4'd8;
   localparam logic [3:0] ST_POP      = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic                   last_ff, last_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [FW-1:0]          fill_ff, fill_in;
   logic [VALUE_WIDTH-1:0] best_val_ff, best_val_in;
   logic                   best_left_ff, best_left_in;
   logic [KEEP_W-1:0]      keep_ff;
   logic [RANK_W-1:0]      rank_ff, rank_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [RANK_W-1:0]      rsp_rank_ff, rsp_rank_in;
   logic                   rsp_final_ff, rsp_final_in;

   logic                   ram_we;
   logic [AW-1:0]          ram_waddr;
   logic [VALUE_WIDTH-1:0] ram_wdata;
   logic                   ram_re;
   logic [AW-1:0]          ram_raddr_a;
   logic [AW-1:0]          ram_raddr_b;
   logic [VALUE_WIDTH-1:0] rd_a;
   logic [VALUE_WIDTH-1:0] rd_b;

   logic [VALUE_WIDTH-1:0] cmp_a;
   logic [VALUE_WIDTH-1:0] cmp_b;
   logic                   cmp_lt;

   logic [CW-1:0]          child_l;
   logic [CW-1:0]          child_r;
   logic                   l_ok;
   logic                   r_ok;
   logic [AW-1:0]          parent;
   logic [FW-1:0]          keep_eff;
   logic                   can_insert;
   logic                   out_free;

   tks_heap_ram #(
      .ADDR_WIDTH  (AW),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_en     (ram_re),
      .rd_addr_a (ram_raddr_a),
      .rd_addr_b (ram_raddr_b),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // The one compare unit: signed less-than on whichever pair the step needs.
   assign cmp_lt = $signed(cmp_a) < $signed(cmp_b);

   // Heap index arithmetic around the current position.
   assign child_l  = {1'b0, pos_ff, 1'b1};
   assign child_r  = CW'(child_l + CW'(1));
   assign l_ok     = child_l < CW'(fill_ff);
   assign r_ok     = child_r < CW'(fill_ff);
   assign parent   = AW'((pos_ff - AW'(1)) >> 1);

   // A zero keep_count acts as one; a value above the heap size saturates.
   always_comb begin
      if (keep_ff == '0) begin
         keep_eff = FW'(1);
      end else if (int'(keep_ff) > MAX_KEEP) begin
         keep_eff = FW'(MAX_KEEP);
      end else begin
         keep_eff = FW'(keep_ff);
      end
   end

   assign can_insert = (fill_ff < keep_eff) && (fill_ff < FW'(MAX_KEEP));
   assign out_free   = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in     = state_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      best_val_in  = best_val_ff;
      best_left_in = best_left_ff;
      rank_in      = rank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_value_in = rsp_value_ff;
      rsp_rank_in  = rsp_rank_ff;
      rsp_final_in = rsp_final_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_wdata    = val_ff;
      ram_re       = 1'b0;
      ram_raddr_a  = '0;
      ram_raddr_b  = '0;
      cmp_a        = rd_a;
      cmp_b        = val_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               val_in  = req.sample_value;
               last_in = req.last_in_set;
               rank_in = '0;
               if (can_insert) begin
                  pos_in   = AW'(fill_ff);
                  fill_in  = FW'(fill_ff + FW'(1));
                  state_in = ST_UP_RD;
               end else begin
                  ram_re      = 1'b1;
                  ram_raddr_a = '0;
                  state_in    = ST_ROOT_CMP;
               end
            end
         end
         ST_UP_RD: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = ST_DONE;
            end else begin
               ram_re      = 1'b1;
               ram_raddr_a = parent;
               state_in    = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            cmp_a  = val_ff;
            cmp_b  = rd_a;
            ram_we = 1'b1;
            if (cmp_lt) begin
               // Parent moves down into the hole; the new value keeps climbing.
               ram_wdata = rd_a;
               pos_in    = parent;
               state_in  = ST_UP_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_ROOT_CMP: begin
            cmp_a = rd_a;
            cmp_b = val_ff;
            if (cmp_lt) begin
               pos_in   = '0;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DN_RD: begin
            if (l_ok) begin
               ram_re      = 1'b1;
               ram_raddr_a = child_l[AW-1:0];
               ram_raddr_b = child_r[AW-1:0];
               state_in    = ST_DN_L;
            end else begin
               ram_we   = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DN_L: begin
            cmp_a        = rd_a;
            cmp_b        = val_ff;
            best_val_in  = cmp_lt ? rd_a : val_ff;
            best_left_in = cmp_lt;
            state_in     = ST_DN_R;
         end
         ST_DN_R: begin
            cmp_a  = rd_b;
            cmp_b  = best_val_ff;
            ram_we = 1'b1;
            if (r_ok && cmp_lt) begin
               ram_wdata = rd_b;
               pos_in    = child_r[AW-1:0];
               state_in  = ST_DN_RD;
            end else if (best_left_ff) begin
               ram_wdata = best_val_ff;
               pos_in    = child_l[AW-1:0];
               state_in  = ST_DN_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (last_ff && (fill_ff != '0)) begin
               state_in = ST_POP_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_POP_RD: begin
            ram_re      = 1'b1;
            ram_raddr_a = '0;
            ram_raddr_b = AW'(fill_ff - FW'(1));
            state_in    = ST_POP;
         end
         ST_POP: begin
            if (out_free) begin
               // The root is the smallest value left; the last entry refills the root.
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_a;
               rsp_rank_in  = rank_ff;
               rsp_final_in = (fill_ff == FW'(1));
               rank_in      = RANK_W'(rank_ff + RANK_W'(1));
               fill_in      = FW'(fill_ff - FW'(1));
               val_in       = rd_b;
               pos_in       = '0;
               state_in     = (fill_ff == FW'(1)) ? ST_IDLE : ST_DN_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         keep_ff      <= KEEP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            keep_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff       <= val_in;
      last_ff      <= last_in;
      pos_ff       <= pos_in;
      best_val_ff  <= best_val_in;
      best_left_ff <= best_left_in;
      rank_ff      <= rank_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rank_ff  <= rsp_rank_in;
      rsp_final_ff <= rsp_final_in;
   end

   assign req.ready        = (state_ff == ST_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.kept_value   = rsp_value_ff;
   assign rsp.rank         = rsp_rank_ff;
   assign rsp.final_result = rsp_final_ff;

endmodule

FILE: rtl/tks_heap_ram.sv
// Heap storage: one write port and two registered read ports.
module tks_heap_ram #(
   parameter int ADDR_WIDTH  = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [ADDR_WIDTH-1:0]  wr_addr,
   input  logic [VALUE_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  logic [ADDR_WIDTH-1:0]  rd_addr_a,
   input  logic [ADDR_WIDTH-1:0]  rd_addr_b,
   output logic [VALUE_WIDTH-1:0] rd_data_a,
   output logic [VALUE_WIDTH-1:0] rd_data_b
);

   logic [VALUE_WIDTH-1:0] mem_ff [2**ADDR_WIDTH];
   logic [VALUE_WIDTH-1:0] rd_a_ff;
   logic [VALUE_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data holds until the next read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

FILE: rtl/tks_checker.sv
// Port-level checks for the top-k largest value selector, bound to the top level.
module tks_checker #(
   parameter int VALUE_WIDTH = 32
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [VALUE_WIDTH-1:0]      rsp_kept_value,
   input logic [tks_pkg::RANK_W-1:0]  rsp_rank,
   input logic                        rsp_final_result
);
   import tks_pkg::*;

   // A stalled word stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp word dropped while stalled");

   // A stalled word keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_kept_value) && $stable(rsp_rank)
                                  && $stable(rsp_final_result))
      else $error("rsp payload changed while stalled");

   // No new input word is taken while a report is still under way.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_result |-> !req_ready)
      else $error("input taken in the middle of a report");

   // Report words count up by one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_result
      |=> !rsp_valid || (rsp_rank == RANK_W'($past(rsp_rank) + RANK_W'(1))))
      else $error("report rank out of sequence");

   // A word right after the final word of a report opens a new report.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_final_result |=> !rsp_valid || (rsp_rank == '0))
      else $error("word after final report word does not start a new report");

endmodule

bind top_k_largest_selector tks_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_tks_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_kept_value   (rsp.kept_value),
   .rsp_rank         (rsp.rank),
   .rsp_final_result (rsp.final_result)
);
